>>> src/cll_pkg.sv
package cll_pkg;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_READ     = 3'd2,
    OP_TO_HEAD  = 3'd3,
    OP_TO_END   = 3'd4,
    OP_STEP     = 3'd5,
    OP_MOVE_POS = 3'd6,
    OP_CLEAR    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_AT_END = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_WALK = 1'b1
  } fsm_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] value;
    logic [8:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_out;
    logic [8:0]  element_count;
    logic        cursor_at_end;
    logic        list_empty;
  } out_item_t;

  // shift command for one stack of cells
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

endpackage

>>> src/cll_cell.sv
module cll_cell #(
  parameter int W = 32
) (
  input  logic                clk,
  input  cll_pkg::stack_ctl_t ctl,
  input  logic [W-1:0]        from_prev,
  input  logic [W-1:0]        from_next,
  output logic [W-1:0]        val
);
  import cll_pkg::*;

  logic [W-1:0] val_r;

  // push: take neighbor toward top; pop: take neighbor toward bottom; else hold
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      val_r <= from_prev;
    end else if (ctl.pop) begin
      val_r <= from_next;
    end
  end

  assign val = val_r;

endmodule

>>> src/cll_stack.sv
module cll_stack #(
  parameter int DEPTH = 256,
  parameter int W     = 32
) (
  input  logic                clk,
  input  cll_pkg::stack_ctl_t ctl,
  input  logic [W-1:0]        push_data,
  output logic [W-1:0]        top
);
  import cll_pkg::*;

  logic [W-1:0] cell_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] prev_d;
    logic [W-1:0] next_d;

    if (i == 0) begin : g_first
      assign prev_d = push_data;
    end else begin : g_mid
      assign prev_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_inner
      assign next_d = cell_q[i+1];
    end

    cll_cell #(.W(W)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .from_prev (prev_d),
      .from_next (next_d),
      .val       (cell_q[i])
    );
  end

  assign top = cell_q[0];

endmodule

>>> src/cursor_linked_list_engine.sv
// Insert, remove, read, step and clear show their result in the cycle after the transfer.
// To head, to end and move to position walk the cursor one element per cycle; once the cursor
// reaches its target, the result is registered and shown.
// Throughput: one item per cycle for single-step operations; a walk holds busy until the cursor reaches its target.
// Reset (synchronous, rst_n low): list empty, cursor at the dummy head, no result pending.
// The receiver cannot stall: out_valid is a one-cycle strobe.
module cursor_linked_list_engine #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cll_pkg::in_item_t  in_item,
  output logic               out_valid,
  output cll_pkg::out_item_t out_item
);
  import cll_pkg::*;

  // The list is kept as a gap buffer: two stacks of cells meeting at the cursor.
  // Left stack holds elements before the cursor (top = element the cursor sits on),
  // right stack holds elements after it (top = element right after the cursor).
  // Insert pushes the right stack, remove pops it, step moves one top across.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int PW = (CW > 9) ? CW : 9;

  fsm_t        state_r, state_nxt;
  logic [CW-1:0] left_cnt_r, left_cnt_nxt;
  logic [CW-1:0] right_cnt_r, right_cnt_nxt;
  logic [CW-1:0] target_r, target_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  stack_ctl_t  lctl, rctl;
  logic [SW-1:0] lpush, rpush;
  logic [SW-1:0] left_top, right_top;

  logic        accept;
  op_t         op;
  logic [CW-1:0] total;
  logic [CW-1:0] total_nxt;
  logic [PW-1:0] pos_w, tot_w;
  logic [SW-1:0] data_sel;
  status_t     status_sel;

  cll_stack #(.DEPTH(CAPACITY), .W(SW)) u_left (
    .clk       (clk),
    .ctl       (lctl),
    .push_data (lpush),
    .top       (left_top)
  );

  cll_stack #(.DEPTH(CAPACITY), .W(SW)) u_right (
    .clk       (clk),
    .ctl       (rctl),
    .push_data (rpush),
    .top       (right_top)
  );

  assign busy   = (state_r != FSM_IDLE);
  assign accept = start && !busy;
  assign op     = op_t'(in_item.operation);
  assign total  = left_cnt_r + right_cnt_r;
  assign pos_w  = PW'(in_item.position);
  assign tot_w  = PW'(total);

  always_comb begin
    state_nxt     = state_r;
    left_cnt_nxt  = left_cnt_r;
    right_cnt_nxt = right_cnt_r;
    target_nxt    = target_r;
    out_valid_nxt = 1'b0;
    lctl          = '0;
    rctl          = '0;
    lpush         = right_top;
    rpush         = left_top;
    data_sel      = '0;
    status_sel    = ST_OK;

    unique case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_INSERT: begin
              out_valid_nxt = 1'b1;
              if (total == CW'(CAPACITY)) begin
                status_sel = ST_FULL;
              end else begin
                rctl.push     = 1'b1;
                rpush         = in_item.value[SW-1:0];
                right_cnt_nxt = right_cnt_r + 1'b1;
              end
            end
            OP_REMOVE, OP_READ: begin
              out_valid_nxt = 1'b1;
              priority if (total == '0) begin
                status_sel = ST_EMPTY;
              end else if (right_cnt_r == '0) begin
                status_sel = ST_AT_END;
              end else begin
                data_sel = right_top;
                if (op == OP_REMOVE) begin
                  rctl.pop      = 1'b1;
                  right_cnt_nxt = right_cnt_r - 1'b1;
                end
              end
            end
            OP_STEP: begin
              out_valid_nxt = 1'b1;
              if (right_cnt_r == '0) begin
                status_sel = ST_AT_END;
              end else begin
                rctl.pop      = 1'b1;
                lctl.push     = 1'b1;
                left_cnt_nxt  = left_cnt_r + 1'b1;
                right_cnt_nxt = right_cnt_r - 1'b1;
              end
            end
            OP_TO_HEAD: begin
              target_nxt = '0;
              state_nxt  = FSM_WALK;
            end
            OP_TO_END: begin
              target_nxt = total;
              state_nxt  = FSM_WALK;
            end
            OP_MOVE_POS: begin
              // stop at the last element when the position lies past the end
              target_nxt = (pos_w > tot_w) ? total : CW'(pos_w);
              state_nxt  = FSM_WALK;
            end
            OP_CLEAR: begin
              out_valid_nxt = 1'b1;
              left_cnt_nxt  = '0;
              right_cnt_nxt = '0;
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      FSM_WALK: begin
        // one element crosses the cursor per cycle until the left count hits target
        priority if (left_cnt_r > target_r) begin
          lctl.pop      = 1'b1;
          rctl.push     = 1'b1;
          left_cnt_nxt  = left_cnt_r - 1'b1;
          right_cnt_nxt = right_cnt_r + 1'b1;
        end else if (left_cnt_r < target_r) begin
          rctl.pop      = 1'b1;
          lctl.push     = 1'b1;
          left_cnt_nxt  = left_cnt_r + 1'b1;
          right_cnt_nxt = right_cnt_r - 1'b1;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase

    // result flags reflect the state after the operation
    total_nxt                   = left_cnt_nxt + right_cnt_nxt;
    out_item_nxt.status         = status_sel;
    out_item_nxt.data_out       = 32'(data_sel);
    out_item_nxt.element_count  = 9'(total_nxt);
    out_item_nxt.cursor_at_end  = (right_cnt_nxt == '0);
    out_item_nxt.list_empty     = (total_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      left_cnt_r  <= '0;
      right_cnt_r <= '0;
      target_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_cnt_r  <= left_cnt_nxt;
      right_cnt_r <= right_cnt_nxt;
      target_r    <= target_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload: no reset needed
  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // single-step operations give their result in the very next cycle
  a_single_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.operation != OP_TO_HEAD && in_item.operation != OP_TO_END
     && in_item.operation != OP_MOVE_POS) |=> out_valid)
    else $error("single-step operation gave no result");

  // the list never holds more than the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((CW + 1)'(left_cnt_r) + (CW + 1)'(right_cnt_r)) <= (CW + 1)'(CAPACITY))
    else $error("element count beyond capacity");

  // no result strobe while the cursor walks
  a_quiet_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_WALK) |-> !out_valid_r)
    else $error("result strobe during walk");

  // walking moves elements across the cursor without changing their number
  a_walk_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_WALK && left_cnt_r != target_r) |=> $stable(left_cnt_r + right_cnt_r))
    else $error("walk changed element count");

  // the walk target never lies past the end of the list
  a_target_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_WALK) |-> (target_r <= total))
    else $error("walk target past end");

endmodule
